// ----- hw/rtl/rbwm_pkg.sv -----
// Shared types and constants of the ring buffer window mean unit.
`default_nettype none

package rbwm_pkg;

  // Default history depth, in entries.
  localparam int unsigned DepthDefault = 256;

  // Fixed field widths.
  localparam int unsigned KindW   = 2;
  localparam int unsigned SampleW = 24;
  localparam int unsigned WindowW = 16;
  localparam int unsigned PeriodW = 16;

  // Fraction bits of the period times sample product (Q8.8 times Q16.8).
  localparam int unsigned ProdFracW = 16;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_PERIOD = 2'd2
  } kind_e;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rbwm_if.sv -----
// Request and result channel interfaces of the ring buffer window mean unit.
`default_nettype none

interface rbwm_in_if
  import rbwm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [KindW-1:0]          kind;
  logic [SampleW-1:0]        sample;
  logic signed [WindowW-1:0] window;
  logic [PeriodW-1:0]        period;

  modport source (output valid, kind, sample, window, period, input ready);
  modport sink   (input valid, kind, sample, window, period, output ready);
endinterface

interface rbwm_out_if
  import rbwm_pkg::*;
#(
  parameter int unsigned FramesW = $clog2(DepthDefault + 1)
) ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] mean;
  logic [FramesW-1:0] frames_used;

  modport source (output valid, mean, frames_used, input ready);
  modport sink   (input valid, mean, frames_used, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rbwm_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module rbwm_div
  import rbwm_pkg::*;
#(
  parameter int unsigned SumW = SampleW + $clog2(DepthDefault),
  parameter int unsigned DivW = $clog2(DepthDefault + 1),
  localparam int unsigned CntW = $clog2(SumW + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] dividend_i,
  input  wire logic [DivW-1:0] divisor_i,
  output div_stat_t            stat_o,
  output logic      [SumW-1:0] quotient_o
);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] rem_q;
  logic [SumW-1:0] dq_q;
  logic [DivW-1:0] dvs_q;

  logic [DivW:0] shifted;
  logic [DivW:0] diff;
  logic          ge;

  // The partial remainder stays below the divisor, so the shifted value
  // is below twice the divisor and one compare settles each bit.
  assign shifted = {rem_q, dq_q[SumW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(SumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivW-1:0] : shifted[DivW-1:0];
      dq_q  <= {dq_q[SumW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dq_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ring_buffer_window_mean_unit.sv -----
// Top level of the ring buffer window mean unit: history memory and query sequencer.
//
//   channel  direction  carries
//   req_i    in         kind, sample, window, period
//   res_o    out        mean, frames_used (one per frame or period query)
//
// An append writes the history as it is taken. A frame query reads
// the history through the single memory read port, then divides the sum in
// the one-bit-per-cycle divider, then loads the result. A period query first
// passes through S_NEWEST, in which the newest sample, read ahead while idle, is
// multiplied by the period. The next request is taken only once the sequencer
// is back in idle, after the result is loaded.
// Reset clears the pointer, the fill count and all control state; the history
// memory is not cleared, since the fill count keeps unwritten entries unread.
// A finished result waits in the output register while the next request is
// taken; only a second result that finds the register still full stalls.
`default_nettype none

module ring_buffer_window_mean_unit
  import rbwm_pkg::*;
#(
  parameter int unsigned Depth = DepthDefault,
  localparam int unsigned AddrW   = $clog2(Depth),
  localparam int unsigned FramesW = $clog2(Depth + 1),
  localparam int unsigned SumW    = SampleW + $clog2(Depth)
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rbwm_in_if.sink   req_i,
  rbwm_out_if.source res_o
);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_NEWEST = 6'b000010,
    S_CLAMP  = 6'b000100,
    S_SUM    = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Ring pointer and fill count.
  logic [AddrW-1:0]   ptr_q, ptr_d;
  logic [FramesW-1:0] filled_q, filled_d;

  // Query working registers.
  logic [SampleW-1:0] window_q, window_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [FramesW-1:0] frames_q, frames_d;
  logic [AddrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FramesW-1:0] issue_q, issue_d;
  logic [FramesW-1:0] acc_q, acc_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               empty_q, empty_d;
  logic               rd_vld_q;

  // Result register.
  logic               out_valid_q;
  logic [SampleW-1:0] mean_q;
  logic [FramesW-1:0] used_q;

  // History memory: one write port, one registered read port.
  logic [SampleW-1:0] mem_q [Depth];
  logic [SampleW-1:0] rdata_q;
  logic [AddrW-1:0]   rd_addr;
  logic               mem_we;
  logic               rd_issue;

  logic               req_accept;
  logic               div_start;
  logic               out_load;
  div_stat_t          div_stat;
  logic [SumW-1:0]    quotient;
  logic [SumW-1:0]    dividend;

  logic [AddrW-1:0]           ptr_next;
  logic [AddrW-1:0]           newest;
  logic [AddrW-1:0]           rd_ptr_next;
  logic [SampleW+PeriodW-1:0] prod;
  logic [FramesW-1:0]         frames_clamp;
  logic [FramesW-1:0]         ptr_ext;
  logic [FramesW-1:0]         start_ext;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;

  // Ring arithmetic works for any depth, not only powers of two.
  assign ptr_next    = (ptr_q == AddrW'(Depth - 1)) ? '0 : ptr_q + 1'b1;
  assign newest      = (ptr_q == '0) ? AddrW'(Depth - 1) : ptr_q - 1'b1;
  assign rd_ptr_next = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;

  // The period window is the integer part of period times the newest sample.
  assign prod = period_q * rdata_q;

  // Clamp the window to one at the bottom and to the fill count at the top.
  always_comb begin
    if (window_q == '0) begin
      frames_clamp = FramesW'(1);
    end else if (window_q > SampleW'(filled_q)) begin
      frames_clamp = filled_q;
    end else begin
      frames_clamp = window_q[FramesW-1:0];
    end
  end

  // The oldest entry of the window sits frames places behind the write pointer.
  // The true result is below the depth, so wrapping in FramesW bits is harmless.
  assign ptr_ext   = FramesW'(ptr_q);
  assign start_ext = (ptr_ext >= frames_clamp) ? ptr_ext - frames_clamp
                                               : ptr_ext + FramesW'(Depth) - frames_clamp;

  assign dividend = sum_q + SumW'(rdata_q);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    filled_d  = filled_q;
    window_d  = window_q;
    period_d  = period_q;
    frames_d  = frames_q;
    rd_ptr_d  = rd_ptr_q;
    issue_d   = issue_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    empty_d   = empty_q;
    mem_we    = 1'b0;
    rd_addr   = rd_ptr_q;
    rd_issue  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        // The newest entry is read ahead so that a period query finds it
        // in the read register in the next cycle.
        rd_addr = newest;
        if (req_accept) begin
          unique case (kind_e'(req_i.kind))
            KIND_APPEND: begin
              mem_we = 1'b1;
              ptr_d  = ptr_next;
              if (filled_q != FramesW'(Depth)) begin
                filled_d = filled_q + 1'b1;
              end
            end
            KIND_FRAME: begin
              if (filled_q == '0) begin
                empty_d  = 1'b1;
                frames_d = '0;
                state_d  = S_DONE;
              end else begin
                empty_d  = 1'b0;
                // A negative window clamps to one.
                window_d = req_i.window[WindowW-1] ? SampleW'(1)
                                                   : SampleW'(req_i.window);
                state_d  = S_CLAMP;
              end
            end
            KIND_PERIOD: begin
              if (filled_q == '0) begin
                empty_d  = 1'b1;
                frames_d = '0;
                state_d  = S_DONE;
              end else begin
                empty_d  = 1'b0;
                period_d = req_i.period;
                state_d  = S_NEWEST;
              end
            end
            default: begin
              // An undefined kind is dropped without effect.
            end
          endcase
        end
      end

      S_NEWEST: begin
        window_d = prod[SampleW+PeriodW-1:ProdFracW];
        state_d  = S_CLAMP;
      end

      S_CLAMP: begin
        frames_d = frames_clamp;
        rd_ptr_d = start_ext[AddrW-1:0];
        issue_d  = frames_clamp;
        acc_d    = frames_clamp;
        sum_d    = '0;
        state_d  = S_SUM;
      end

      S_SUM: begin
        // Reads are issued one per cycle and summed as they return.
        if (issue_q != '0) begin
          rd_issue = 1'b1;
          rd_ptr_d = rd_ptr_next;
          issue_d  = issue_q - 1'b1;
        end
        if (rd_vld_q) begin
          sum_d = dividend;
          acc_d = acc_q - 1'b1;
          if (acc_q == FramesW'(1)) begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      filled_q    <= '0;
      issue_q     <= '0;
      acc_q       <= '0;
      rd_vld_q    <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      filled_q <= filled_d;
      issue_q  <= issue_d;
      acc_q    <= acc_d;
      rd_vld_q <= rd_issue;
      empty_q  <= empty_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
    period_q <= period_d;
    frames_q <= frames_d;
    rd_ptr_q <= rd_ptr_d;
    sum_q    <= sum_d;
    if (out_load) begin
      mean_q <= empty_q ? '0 : quotient[SampleW-1:0];
      used_q <= frames_q;
    end
  end

  // History memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ptr_q] <= req_i.sample;
    end
    rdata_q <= mem_q[rd_addr];
  end

  rbwm_div #(
    .SumW (SumW),
    .DivW (FramesW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (frames_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.mean        = mean_q;
  assign res_o.frames_used = used_q;

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FramesW'(Depth))
    else $error("fill count above depth");

  // An accepted append raises the fill count unless it is already full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && req_i.kind == KIND_APPEND) |=>
      (filled_q == $past(filled_q) + 1'b1) || (filled_q == FramesW'(Depth)))
    else $error("append did not update fill count");

  // Every returning read still has an entry left to account for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (acc_q != '0))
    else $error("read returned with no entry outstanding");

  // The divider only runs while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == S_DIV))
    else $error("divider busy outside divide state");

  // A loaded result never averages more entries than are stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> res_o.valid && (res_o.frames_used <= filled_q))
    else $error("result frame count above fill count");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the ring buffer window mean unit.
`default_nettype none

module tb_top;
  import rbwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // History geometry of the instance under test.
  localparam int unsigned Depth   = DepthDefault;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned FramesW = $clog2(Depth + 1);

  // The undefined request kind, which the unit must accept and ignore.
  localparam logic [KindW-1:0] KindIgnored = 2'd3;

  // Cycles with no request or result taken before the run is declared hung.
  // A full-window query and the long receiver hold-off both end well within
  // this limit, so it leaves a wide margin.
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned HoldCycles = 2000;
  // Settling time after the last result, a bit over one full-window query.
  localparam int unsigned TailCycles = 400;

  typedef struct {
    logic [KindW-1:0]          kind;
    logic [SampleW-1:0]        sample;
    logic signed [WindowW-1:0] window;
    logic [PeriodW-1:0]        period;
  } rate_req_t;

  typedef struct {
    logic [SampleW-1:0] mean;
    logic [FramesW-1:0] frames_used;
  } window_mean_t;

  logic clk_i;
  logic rst_ni;

  rbwm_in_if                          req_if ();
  rbwm_out_if #(.FramesW(FramesW))    res_if ();

  ring_buffer_window_mean_unit #(
    .Depth(Depth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // Requests waiting to be driven, and the means still owed by the unit.
  rate_req_t    pending_reqs_q[$];
  window_mean_t expected_means_q[$];

  // Our own copy of the sample history, mirrored on every accepted append.
  logic [SampleW-1:0] rate_history[Depth];
  logic [AddrW-1:0]   hist_wr_ptr;
  logic [FramesW-1:0] hist_fill;

  // Idle controls, changed per phase by the stimulus process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_wanted    = 1'b0;

  bit          req_took = 1'b0;
  bit          hold_started = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  int unsigned mismatches = 0;
  int unsigned n_appends = 0;
  int unsigned n_frame_q = 0;
  int unsigned n_period_q = 0;
  int unsigned n_ignored = 0;
  int unsigned n_results = 0;
  int unsigned n_clamped = 0;
  int unsigned peak_fill = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mean of the newest `want` entries after clamping the window to 1..fill.
  // An empty history gives a zero mean over zero frames.
  function automatic window_mean_t window_mean(longint unsigned want);
    window_mean_t     res;
    longint unsigned  sum;
    logic [AddrW-1:0] idx;
    res = '{mean: '0, frames_used: '0};
    sum = 0;
    if (hist_fill != 0) begin
      if (want < 1) want = 1;
      if (want > hist_fill) begin
        want = hist_fill;
        n_clamped++;
      end
      // The pointer wraps modulo the depth, so a full window starts at it.
      idx = hist_wr_ptr - AddrW'(want);
      for (int unsigned k = 0; k < want; k++) begin
        sum += rate_history[idx];
        idx++;
      end
      res.mean        = SampleW'(sum / want);
      res.frames_used = FramesW'(want);
    end
    return res;
  endfunction

  // Updates the history copy for one accepted request and queues the mean
  // that a query owes.
  function automatic void predict_request(rate_req_t rq);
    longint unsigned  want;
    logic [AddrW-1:0] newest;
    if (rq.kind == KIND_APPEND) begin
      rate_history[hist_wr_ptr] = rq.sample;
      hist_wr_ptr++;
      if (hist_fill < Depth) hist_fill++;
      if (hist_fill > peak_fill) peak_fill = hist_fill;
      n_appends++;
    end else if (rq.kind == KIND_FRAME) begin
      // A negative window behaves like a window of one.
      want = rq.window[WindowW-1] ? 64'd1 : 64'(rq.window);
      expected_means_q.push_back(window_mean(want));
      n_frame_q++;
    end else if (rq.kind == KIND_PERIOD) begin
      // Q8.8 period times Q16.8 sample; the integer part is the frame count.
      want = 0;
      if (hist_fill != 0) begin
        newest = hist_wr_ptr - AddrW'(1);
        want = (64'(rq.period) * 64'(rate_history[newest])) >> ProdFracW;
      end
      expected_means_q.push_back(window_mean(want));
      n_period_q++;
    end else begin
      n_ignored++;
    end
  endfunction

  // Request driver: a new request is presented only once the previous one
  // was taken or nothing was on offer, so valid never drops mid-handshake.
  always @(negedge clk_i) begin
    rate_req_t rq;
    if (rst_ni) begin
      if (!req_if.valid || req_took) begin
        if (pending_reqs_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rq = pending_reqs_q.pop_front();
          req_if.valid  <= 1'b1;
          req_if.kind   <= rq.kind;
          req_if.sample <= rq.sample;
          req_if.window <= rq.window;
          req_if.period <= rq.period;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver. The long hold-off is counted here so that the sender
  // keeps offering requests while the unit backs up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_wanted && !hold_started) begin
        hold_started <= 1'b1;
        hold_left    <= HoldCycles;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: predicts on every accepted request, checks every accepted
  // result against the oldest expectation, and watches for a hang.
  always @(posedge clk_i) begin
    rate_req_t    rq;
    window_mean_t exp_mean;
    if (rst_ni) begin
      req_took <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        rq.kind   = req_if.kind;
        rq.sample = req_if.sample;
        rq.window = req_if.window;
        rq.period = req_if.period;
        predict_request(rq);
      end
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (expected_means_q.size() == 0) begin
          $error("unexpected result: mean=%h frames_used=%0d",
                 res_if.mean, res_if.frames_used);
          mismatches++;
        end else begin
          exp_mean = expected_means_q.pop_front();
          if (res_if.mean !== exp_mean.mean) begin
            $error("mean: expected %h, got %h", exp_mean.mean, res_if.mean);
            mismatches++;
          end
          if (res_if.frames_used !== exp_mean.frames_used) begin
            $error("frames_used: expected %0d, got %0d",
                   exp_mean.frames_used, res_if.frames_used);
            mismatches++;
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchLimit) begin
        $display("timeout: nothing accepted for %0d cycles", WatchLimit);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_req(logic [KindW-1:0] kind, logic [SampleW-1:0] sample,
                          logic signed [WindowW-1:0] window, logic [PeriodW-1:0] period);
    rate_req_t rq;
    rq.kind   = kind;
    rq.sample = sample;
    rq.window = window;
    rq.period = period;
    pending_reqs_q.push_back(rq);
  endtask

  // Half the samples are small rates, so that period windows stay modest.
  function automatic logic [SampleW-1:0] rand_sample();
    if ($urandom_range(0, 1) == 0) return SampleW'($urandom_range(0, 4096));
    return SampleW'($urandom);
  endfunction

  // Mostly short windows to keep queries fast, some up to past the depth,
  // and some across the whole signed range.
  function automatic logic signed [WindowW-1:0] rand_window();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return WindowW'($urandom_range(0, 16));
    if (pick < 85) return WindowW'($urandom_range(0, 300));
    return WindowW'($urandom);
  endfunction

  function automatic logic [PeriodW-1:0] rand_period();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return PeriodW'($urandom_range(0, 1024));
    return PeriodW'($urandom);
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_req(KIND_APPEND, rand_sample(), rand_window(), rand_period());
      end else if (pick < 70) begin
        push_req(KIND_FRAME, rand_sample(), rand_window(), rand_period());
      end else if (pick < 96) begin
        push_req(KIND_PERIOD, rand_sample(), rand_window(), rand_period());
      end else begin
        push_req(KindIgnored, rand_sample(), rand_window(), rand_period());
      end
    end
  endtask

  // Blocks until every queued request was taken and every mean has arrived.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs_q.size() != 0 || req_if.valid || expected_means_q.size() != 0);
  endtask

  initial begin
    // Known values on every input from time zero.
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.kind   = KIND_APPEND;
    req_if.sample = '0;
    req_if.window = '0;
    req_if.period = '0;
    res_if.ready  = 1'b0;
    hist_wr_ptr   = '0;
    hist_fill     = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed part, starting from an empty history.
    push_req(KIND_FRAME, '0, 16'sd5, '0);           // empty history, frame query
    push_req(KIND_PERIOD, '0, '0, 16'hFFFF);        // empty history, period query
    push_req(KIND_APPEND, 24'hFFFFFF, '0, '0);      // largest sample
    push_req(KIND_APPEND, 24'h000000, '0, '0);      // smallest sample
    push_req(KIND_APPEND, 24'h000100, '0, '0);
    push_req(KIND_FRAME, '0, 16'sd0, '0);           // zero window is taken as one
    push_req(KIND_FRAME, '0, -16'sd1, '0);          // negative window
    push_req(KIND_FRAME, '0, 16'h8000, '0);         // most negative window
    push_req(KIND_FRAME, '0, 16'sh7FFF, '0);        // saturates at the fill count
    push_req(KIND_FRAME, '0, 16'sd2, '0);
    push_req(KIND_PERIOD, '0, '0, 16'h0000);        // zero period gives one frame
    push_req(KIND_PERIOD, '0, '0, 16'hFFFF);        // huge product saturates
    push_req(KIND_APPEND, 24'h000200, '0, '0);      // 2.0 frames per second
    push_req(KIND_PERIOD, '0, '0, 16'h0180);        // 1.5 s at 2.0 gives three frames
    push_req(KindIgnored, 24'hFFFFFF, 16'sh7FFF, 16'hFFFF);
    push_req(KIND_FRAME, '0, 16'sd4, '0);           // whole history after the ignored one
    push_req(KIND_APPEND, 24'hFFFFFF, '0, '0);
    push_req(KIND_PERIOD, '0, '0, 16'h0001);        // tiny period on a large sample
    push_req(KIND_FRAME, '0, 16'sd5, '0);
    wait_drained();

    // Random phases; each ends with the sender paused until the unit drains.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      queue_random(240);
      wait_drained();
    end

    // Back-pressure: the receiver holds off while short queries keep coming,
    // so the unit fills its result register and stops taking requests.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_wanted    = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) push_req(KIND_APPEND, rand_sample(), '0, '0);
      else push_req(KIND_FRAME, '0, WindowW'($urandom_range(1, 4)), '0);
    end
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (expected_means_q.size() != 0) begin
      $error("%0d means never arrived", expected_means_q.size());
      mismatches++;
    end

    $display("covered %0d appends, %0d frame and %0d period queries, %0d ignored requests",
             n_appends, n_frame_q, n_period_q, n_ignored);
    $display("checked %0d means, %0d windows clamped at the fill, peak fill %0d of %0d",
             n_results, n_clamped, peak_fill, Depth);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/rbwm_pkg.sv
hw/rtl/rbwm_if.sv
hw/rtl/rbwm_div.sv
hw/rtl/ring_buffer_window_mean_unit.sv
test/tb_top.sv
